// File: rtl/dslr_pkg.sv
`default_nettype none

package dslr_pkg;

  // Command codes carried on the input channel
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Extra bits over the coordinate width for the signed decision terms
  localparam int DEC_EXTRA = 6;
  localparam int INC_EXTRA = 5;
  localparam int BND_EXTRA = 4;

  // Entries in the command queue between front and back
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

endpackage

`default_nettype wire

// File: rtl/dslr_in_if.sv
`default_nettype none

// Command channel: start a line or advance one double step
interface dslr_in_if #(
  parameter int COORD_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_stop;
  logic [COORD_BITS-1:0] y_stop;

  modport source (output valid, opcode, x_start, y_start, x_stop, y_stop, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_stop, y_stop, output ready);
endinterface

`default_nettype wire

// File: rtl/dslr_out_if.sv
`default_nettype none

// Pixel channel: one plotted pixel per item
interface dslr_out_if #(
  parameter int COORD_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/dslr_front.sv
`default_nettype none

module dslr_front #(
  parameter int  COORD_BITS = 10,
  parameter type cmd_t      = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  dslr_in_if.sink   cmd,
  output logic      q_valid,
  input  wire logic q_ready,
  output cmd_t      q_item
);
  import dslr_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int IB = COORD_BITS + INC_EXTRA;
  localparam int BB = COORD_BITS + BND_EXTRA;
  localparam int DB = COORD_BITS + DEC_EXTRA;

  typedef struct packed {
    op_t          op;
    logic         swapped;
    logic         minor_down;
    logic [W-1:0] a1;
    logic [W-1:0] b1;
    logic [W-1:0] a2;
    logic [W-1:0] b2;
    logic [W-1:0] dmaj;
    logic [W-1:0] dmin;
  } stage_t;

  stage_t        s1;
  stage_t        s1_next;
  logic          s1_valid;
  logic          s1_ready;

  logic [W:0]    ddx;
  logic [W:0]    ddy;
  logic [W-1:0]  adx;
  logic [W-1:0]  ady;
  logic          neg_x;
  logic          neg_y;
  logic          flip;
  logic [W-1:0]  sa1, sb1, sa2, sb2;

  logic signed [IB-1:0] maj_e;
  logic signed [IB-1:0] min_e;
  logic signed [IB-1:0] incr_dbl;
  logic signed [IB-1:0] bound_w;
  logic signed [IB-1:0] incr_sgl;
  logic signed [DB-1:0] dec_w;
  logic                 steep;

  // Stage one: deltas, axis swap and endpoint ordering
  always_comb begin
    ddx   = {1'b0, cmd.x_stop} - {1'b0, cmd.x_start};
    ddy   = {1'b0, cmd.y_stop} - {1'b0, cmd.y_start};
    neg_x = ddx[W];
    neg_y = ddy[W];
    adx   = neg_x ? W'(-ddx) : ddx[W-1:0];
    ady   = neg_y ? W'(-ddy) : ddy[W-1:0];

    s1_next            = '0;
    s1_next.op         = op_t'(cmd.opcode);
    s1_next.swapped    = ady > adx;
    s1_next.minor_down = neg_x ^ neg_y;
    if (s1_next.swapped) begin
      sa1 = cmd.y_start; sb1 = cmd.x_start; sa2 = cmd.y_stop; sb2 = cmd.x_stop;
      flip = neg_y;
      s1_next.dmaj = ady;
      s1_next.dmin = adx;
    end else begin
      sa1 = cmd.x_start; sb1 = cmd.y_start; sa2 = cmd.x_stop; sb2 = cmd.y_stop;
      flip = neg_x;
      s1_next.dmaj = adx;
      s1_next.dmin = ady;
    end
    // order so the major coordinate rises
    if (flip) begin
      s1_next.a1 = sa2; s1_next.b1 = sb2; s1_next.a2 = sa1; s1_next.b2 = sb1;
    end else begin
      s1_next.a1 = sa1; s1_next.b1 = sb1; s1_next.a2 = sa2; s1_next.b2 = sb2;
    end
  end

  assign s1_ready  = !s1_valid || q_ready;
  assign cmd.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && cmd.valid) begin
      s1 <= s1_next;
    end
  end

  // Stage two: decision setup, written into the queue
  always_comb begin
    maj_e    = IB'(s1.dmaj);
    min_e    = IB'(s1.dmin);
    incr_dbl = (min_e <<< 2) - (maj_e <<< 1);
    steep    = !incr_dbl[IB-1];
    bound_w  = steep ? (min_e <<< 1) - (maj_e <<< 1) : (min_e <<< 1);
    incr_sgl = bound_w <<< 1;
    dec_w    = steep ? DB'(incr_sgl) + DB'(maj_e) : DB'(incr_sgl) - DB'(maj_e);

    q_item               = '0;
    q_item.opcode        = s1.op;
    q_item.swapped       = s1.swapped;
    q_item.minor_down    = s1.minor_down;
    q_item.odd_length    = s1.dmaj[0];
    q_item.steep_half    = steep;
    q_item.short_line    = (s1.dmaj[W-1:1] == '0);
    q_item.major_pos     = s1.a1;
    q_item.minor_pos     = s1.b1;
    q_item.major_stop    = s1.dmaj[0] ? s1.a2 - W'(1) : s1.a2;
    q_item.end_major     = s1.a2;
    q_item.end_minor     = s1.b2;
    q_item.decision      = dec_w;
    q_item.incr_single   = incr_sgl;
    q_item.incr_double   = incr_dbl;
    q_item.pattern_bound = bound_w[BB-1:0];
  end

  assign q_valid = s1_valid;

  // A setup item held back by a full queue keeps its contents
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !q_ready |=> s1_valid && $stable(s1))
    else $error("front stage lost or changed a stalled item");

endmodule

`default_nettype wire

// File: rtl/dslr_cmd_queue.sv
`default_nettype none

module dslr_cmd_queue #(
  parameter type item_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);
  import dslr_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != QUEUE_DEPTH;
  assign pop_valid  = count != 2'd0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_DEPTH)
    else $error("command queue overfilled");

  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr ^ rd_ptr) == count[0])
    else $error("command queue pointers disagree with fill level");

endmodule

`default_nettype wire

// File: rtl/dslr_back.sv
`default_nettype none

module dslr_back #(
  parameter int  COORD_BITS = 10,
  parameter type cmd_t      = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire cmd_t  q_item,
  dslr_out_if.source pixel
);
  import dslr_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int IB = COORD_BITS + INC_EXTRA;
  localparam int BB = COORD_BITS + BND_EXTRA;
  localparam int DB = COORD_BITS + DEC_EXTRA;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         last;
  } pix_t;

  function automatic pix_t make_pix(logic sw, logic [W-1:0] maj, logic [W-1:0] mnr,
                                    logic last);
    pix_t p;
    p.x    = sw ? mnr : maj;
    p.y    = sw ? maj : mnr;
    p.last = last;
    return p;
  endfunction

  // Line state
  logic                 line_active, line_active_next;
  logic                 axes_swapped, axes_swapped_next;
  logic                 minor_down, minor_down_next;
  logic                 odd_length, odd_length_next;
  logic                 steep_half, steep_half_next;
  logic [W-1:0]         major_pos, major_pos_next;
  logic [W-1:0]         minor_pos, minor_pos_next;
  logic [W-1:0]         major_stop, major_stop_next;
  logic [W-1:0]         end_major, end_major_next;
  logic [W-1:0]         end_minor, end_minor_next;
  logic signed [DB-1:0] decision, decision_next;
  logic signed [IB-1:0] incr_single, incr_single_next;
  logic signed [IB-1:0] incr_double, incr_double_next;
  logic signed [BB-1:0] pattern_bound, pattern_bound_next;

  // Pending pixels, slot 0 drives the output
  pix_t       pix [3];
  pix_t       pix_next [3];
  logic [1:0] pix_cnt, pix_cnt_next;

  logic                 advance;
  logic                 list_free;
  logic                 exec;
  logic                 single;
  logic                 below;
  logic                 first_up;
  logic                 second_up;
  logic                 done;
  logic [W-1:0]         m1, m2, n1, n2;
  logic signed [DB-1:0] bound_ext;

  assign advance   = (pix_cnt != 2'd0) && pixel.ready;
  assign list_free = (pix_cnt == 2'd0) || ((pix_cnt == 2'd1) && pixel.ready);
  assign q_ready   = list_free;
  assign exec      = q_valid && list_free;

  // Double-step pattern choice
  always_comb begin
    bound_ext = DB'(pattern_bound);
    single    = steep_half ? !decision[DB-1] : decision[DB-1];
    below     = decision < bound_ext;
    first_up  = single ? steep_half : !below;
    second_up = single ? steep_half : below;
    m1        = major_pos + W'(1);
    m2        = major_pos + W'(2);
    n1        = first_up ? (minor_down ? minor_pos - W'(1) : minor_pos + W'(1)) : minor_pos;
    n2        = second_up ? (minor_down ? n1 - W'(1) : n1 + W'(1)) : n1;
    done      = m2 == major_stop;
  end

  // Command execution
  always_comb begin
    line_active_next   = line_active;
    axes_swapped_next  = axes_swapped;
    minor_down_next    = minor_down;
    odd_length_next    = odd_length;
    steep_half_next    = steep_half;
    major_pos_next     = major_pos;
    minor_pos_next     = minor_pos;
    major_stop_next    = major_stop;
    end_major_next     = end_major;
    end_minor_next     = end_minor;
    decision_next      = decision;
    incr_single_next   = incr_single;
    incr_double_next   = incr_double;
    pattern_bound_next = pattern_bound;
    pix_next[0]        = pix[0];
    pix_next[1]        = pix[1];
    pix_next[2]        = pix[2];
    pix_cnt_next       = 2'd0;

    case (q_item.opcode)
      OP_START: begin
        axes_swapped_next  = q_item.swapped;
        minor_down_next    = q_item.minor_down;
        odd_length_next    = q_item.odd_length;
        steep_half_next    = q_item.steep_half;
        major_pos_next     = q_item.major_pos;
        minor_pos_next     = q_item.minor_pos;
        major_stop_next    = q_item.major_stop;
        end_major_next     = q_item.end_major;
        end_minor_next     = q_item.end_minor;
        decision_next      = q_item.decision;
        incr_single_next   = q_item.incr_single;
        incr_double_next   = q_item.incr_double;
        pattern_bound_next = q_item.pattern_bound;
        line_active_next   = !q_item.short_line;
        pix_next[0] = make_pix(q_item.swapped, q_item.major_pos, q_item.minor_pos,
                               q_item.short_line && !q_item.odd_length);
        pix_next[1] = make_pix(q_item.swapped, q_item.end_major, q_item.end_minor, 1'b1);
        pix_cnt_next = (q_item.short_line && q_item.odd_length) ? 2'd2 : 2'd1;
      end
      OP_STEP: begin
        if (line_active) begin
          decision_next    = decision + (single ? DB'(incr_single) : DB'(incr_double));
          major_pos_next   = m2;
          minor_pos_next   = n2;
          line_active_next = !done;
          pix_next[0]  = make_pix(axes_swapped, m1, n1, 1'b0);
          pix_next[1]  = make_pix(axes_swapped, m2, n2, done && !odd_length);
          pix_next[2]  = make_pix(axes_swapped, end_major, end_minor, 1'b1);
          pix_cnt_next = (done && odd_length) ? 2'd3 : 2'd2;
        end
      end
      default: begin
        pix_cnt_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      pix_cnt     <= 2'd0;
    end else if (exec) begin
      line_active <= line_active_next;
      pix_cnt     <= pix_cnt_next;
    end else if (advance) begin
      pix_cnt     <= pix_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      axes_swapped  <= axes_swapped_next;
      minor_down    <= minor_down_next;
      odd_length    <= odd_length_next;
      steep_half    <= steep_half_next;
      major_pos     <= major_pos_next;
      minor_pos     <= minor_pos_next;
      major_stop    <= major_stop_next;
      end_major     <= end_major_next;
      end_minor     <= end_minor_next;
      decision      <= decision_next;
      incr_single   <= incr_single_next;
      incr_double   <= incr_double_next;
      pattern_bound <= pattern_bound_next;
      pix[0]        <= pix_next[0];
      pix[1]        <= pix_next[1];
      pix[2]        <= pix_next[2];
    end else if (advance) begin
      pix[0] <= pix[1];
      pix[1] <= pix[2];
    end
  end

  assign pixel.valid      = pix_cnt != 2'd0;
  assign pixel.pixel_x    = pix[0].x;
  assign pixel.pixel_y    = pix[0].y;
  assign pixel.last_pixel = pix[0].last;

  // The closing pixel of a line is always the final pending entry
  a_last_is_tail: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pix[0].last |-> pix_cnt == 2'd1)
    else $error("last pixel shown with further pixels pending");

  // While a line runs, no pending pixel closes it
  a_active_not_last: assert property (@(posedge clk) disable iff (rst)
    line_active && pix_cnt != 2'd0 |-> !pix[0].last)
    else $error("last pixel marked on a line still active");

endmodule

`default_nettype wire

// File: rtl/double_step_line_rasterizer.sv
`default_nettype none

// Channel  Direction  Payload                                  Item
// cmd      in         opcode, x_start, y_start, x_stop, y_stop  start a line or one double step
// pixel    out        pixel_x, pixel_y, last_pixel              one pixel to plot
//
// The front registers deltas, swap and ordering once, then forms the decision terms on
// the way into a two-entry queue; a first pixel passes the setup register and the queue
// into the pending pixel list. The back executes one queued command as that list empties
// and shows one pixel per cycle while the pixel port is ready, so a step yields two
// pixels (three on an odd end), a start one or two; the single pixel port sets that rate.
// Synchronous active-high reset clears the line, the queue and the pending pixels.
// Front and back stall independently: a held pixel port fills the queue and the setup
// register, then holds cmd.

module double_step_line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dslr_in_if.sink    cmd,
  dslr_out_if.source pixel
);
  import dslr_pkg::*;

  localparam int IB = COORD_BITS + INC_EXTRA;
  localparam int BB = COORD_BITS + BND_EXTRA;
  localparam int DB = COORD_BITS + DEC_EXTRA;

  typedef struct packed {
    dslr_pkg::op_t         opcode;
    logic                  swapped;
    logic                  minor_down;
    logic                  odd_length;
    logic                  steep_half;
    logic                  short_line;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] major_stop;
    logic [COORD_BITS-1:0] end_major;
    logic [COORD_BITS-1:0] end_minor;
    logic signed [DB-1:0]  decision;
    logic signed [IB-1:0]  incr_single;
    logic signed [IB-1:0]  incr_double;
    logic signed [BB-1:0]  pattern_bound;
  } cmd_t;

  logic push_valid;
  logic push_ready;
  cmd_t push_item;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_item;

  dslr_front #(
    .COORD_BITS (COORD_BITS),
    .cmd_t      (cmd_t)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (push_valid),
    .q_ready (push_ready),
    .q_item  (push_item)
  );

  dslr_cmd_queue #(
    .item_t (cmd_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dslr_back #(
    .COORD_BITS (COORD_BITS),
    .cmd_t      (cmd_t)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_item  (pop_item),
    .pixel   (pixel)
  );

endmodule

`default_nettype wire
